### rtl/olad_pkg.sv
// Package: types, codes and defaults for the ordered list block.
`timescale 1ns / 1ps
package olad_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   count;
    } out_item_t;

    // Per-cycle commands broadcast along the row of cells
    typedef struct packed {
        logic append_en;
        logic delete_en;
    } cell_ctrl_t;

endpackage

### rtl/olad_cell.sv
// One list slot: holds an entry, compares it with the key and shifts towards the head.
`timescale 1ns / 1ps
module olad_cell #(
    parameter int DATA_WIDTH = olad_pkg::DATA_WIDTH_DEF,
    parameter int OCC_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                    clk,
    input  olad_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]   key,
    input  logic [OCC_W-1:0]        occ,
    input  logic                    hit_in,
    input  logic [DATA_WIDTH-1:0]   next_data,
    output logic                    hit_out,
    output logic [DATA_WIDTH-1:0]   data
);
    import olad_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  held;
    logic                  match;

    assign held    = OCC_W'(IDX) < occ;
    assign match   = held && (data_reg == key);
    assign hit_out = hit_in | match;
    assign data    = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.append_en && (occ == OCC_W'(IDX)))
        begin
            data_next = key;
        end
        else if (ctrl.delete_en && hit_out)
        begin
            // slots at and past the removed entry take their neighbour's value
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

### rtl/ordered_list_append_delete_top.sv
// Top level: bounded ordered list with append at tail and delete by value.
// The result item is registered: it appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while results are taken; the combinational path is the key compare in
// every cell plus the first-match chain along the row of cells.
// A result not yet taken holds in_ready low; one taken in the same cycle lets the next item in.
// Reset (rst_n, asynchronous, active low) empties the list and the output;
// entry contents are left as they are, only slots below the count are read.
`timescale 1ns / 1ps
module ordered_list_append_delete_top #(
    parameter int DEPTH      = olad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olad_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  olad_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output olad_pkg::out_item_t  out_item
);
    import olad_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;
    logic                  in_fire;
    logic                  full;
    logic                  found;
    logic [DATA_WIDTH-1:0] key;
    cell_ctrl_t            ctrl;
    status_t               status;

    logic                  hit_chain [DEPTH+1];
    logic [DATA_WIDTH-1:0] data_chain [DEPTH+1];

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign full     = occ_reg == OCC_W'(DEPTH);
    assign key      = DATA_WIDTH'(in_item.value);

    assign hit_chain[0]      = 1'b0;
    assign data_chain[DEPTH] = '0;
    assign found             = hit_chain[DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            olad_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .OCC_W      (OCC_W),
                .IDX        (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .key       (key),
                .occ       (occ_reg),
                .hit_in    (hit_chain[g]),
                .next_data (data_chain[g+1]),
                .hit_out   (hit_chain[g+1]),
                .data      (data_chain[g])
            );
        end
    endgenerate

    always_comb
    begin
        ctrl     = '0;
        status   = ST_DONE;
        occ_next = occ_reg;
        unique case (in_item.op)
            OP_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.append_en = in_fire;
                    occ_next       = occ_reg + OCC_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (!found)
                begin
                    status = ST_NOT_FOUND;
                end
                else
                begin
                    ctrl.delete_en = in_fire;
                    occ_next       = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
        out_item_next.status = status;
        out_item_next.count  = COUNT_W'(occ_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_item.op == OP_APPEND && full) |=> $stable(occ_reg))
        else $error("refused append changed occupancy");

    a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_item.op == OP_APPEND && !full)
        |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("append did not grow list");

    a_delete_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_item.op == OP_DELETE && found)
        |=> occ_reg == $past(occ_reg) - OCC_W'(1))
        else $error("delete did not shrink list");

    a_found_held: assert property (@(posedge clk) disable iff (!rst_n)
        found |-> occ_reg != '0)
        else $error("match reported in empty list");

endmodule

### sim/olad_result_checker.sv
// Checker: watches both channels, predicts each result item and compares it.
`timescale 1ns / 1ps
module olad_result_checker
    import olad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        errors,
    output int        outstanding
);

    localparam int LIST_DEPTH = DEPTH_DEF;

    logic [VALUE_W-1:0] list_slots [LIST_DEPTH];
    int                 list_len;
    out_item_t          pending_results [$];

    // Applies one item to the shadow list and returns the result it causes
    function automatic out_item_t apply_item(in_item_t it);
        out_item_t r;
        int        hit;
        r.status = ST_DONE;
        if (it.op == OP_APPEND) begin
            if (list_len >= LIST_DEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                list_slots[list_len] = it.value;
                list_len++;
            end
        end
        else begin
            hit = -1;
            for (int i = 0; i < list_len; i++) begin
                if (hit < 0 && list_slots[i] == it.value) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end
            else begin
                // close the gap, keep order
                for (int i = hit; i + 1 < list_len; i++) begin
                    list_slots[i] = list_slots[i + 1];
                end
                list_len--;
            end
        end
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        int        bad;
        if (!rst_n) begin
            list_len = 0;
            pending_results.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else begin
            bad = 0;
            // result first: it belongs to an item accepted earlier
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item status=%0d count=%0d",
                             $time, out_item.status, out_item.count);
                    bad++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (out_item.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, out_item.status);
                        bad++;
                    end
                    if (out_item.count !== want.count) begin
                        $display("%0t: count mismatch: expected %0d, actual %0d",
                                 $time, want.count, out_item.count);
                        bad++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                pending_results.push_back(apply_item(in_item));
            end
            errors      <= errors + bad;
            outstanding <= pending_results.size();
        end
    end

endmodule

### sim/tb_ordered_list_append_delete_top.sv
// Testbench top: stimulus, idling on both channels and the final verdict.
`timescale 1ns / 1ps
module tb_ordered_list_append_delete_top;
    import olad_pkg::*;

    localparam int RANDOM_ITEMS = 850;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    int        errors;
    int        outstanding;
    bit        quiet;
    logic [VALUE_W-1:0] value_pool [8];

    ordered_list_append_delete_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    olad_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic refresh_pool();
        int r;
        int s;
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 8);
            if (r < 40)
                value_pool[i] = s - 4;
            else if (r < 48)
                value_pool[i] = 32'h8000_0000;
            else if (r < 56)
                value_pool[i] = 32'h7fff_ffff;
            else
                value_pool[i] = $urandom;
        end
    endtask

    task automatic send_item(op_t op, logic [VALUE_W-1:0] v);
        int g;
        g = quiet ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, value: v};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // outstanding is registered, so look at it from the next edge after the last accept
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // receiver: busy stretches with random stalls in between
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            g = gap_len();
            if (!quiet && g > 0) begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        int   sent;
        int   phase_len;
        int   mode;
        int   pct_append;
        op_t  op;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        quiet    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty delete, fill with extremes and duplicates, full, deletes
        send_item(OP_DELETE, 32'd0);
        send_item(OP_APPEND, 32'h8000_0000);
        send_item(OP_APPEND, 32'h7fff_ffff);
        send_item(OP_APPEND, 32'd0);
        send_item(OP_APPEND, 32'hffff_ffff);
        send_item(OP_APPEND, 32'd5);
        send_item(OP_APPEND, 32'd5);
        for (int i = 1; i <= 9; i++) begin
            send_item(OP_APPEND, 32'(i * 3 + 100));
        end
        send_item(OP_APPEND, 32'd5);
        send_item(OP_APPEND, 32'd77);
        send_item(OP_DELETE, 32'd99);
        send_item(OP_DELETE, 32'd5);
        send_item(OP_DELETE, 32'h8000_0000);
        send_item(OP_DELETE, 32'd127);
        send_item(OP_DELETE, 32'hffff_ffff);
        send_item(OP_APPEND, 32'h5555_aaaa);
        wait_drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            refresh_pool();
            phase_len = $urandom_range(20, 60);
            mode      = $urandom_range(0, 2);
            quiet     = ($urandom_range(0, 3) == 0);
            pct_append = (mode == 0) ? 50 : (mode == 1) ? 80 : 20;
            for (int k = 0; k < phase_len; k++) begin
                op = ($urandom_range(0, 99) < pct_append) ? OP_APPEND : OP_DELETE;
                send_item(op, pick_value());
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                wait_drain();
        end
        quiet = 1'b0;

        wait_drain();
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

### ordered_list_append_delete_top.f
rtl/olad_pkg.sv
rtl/olad_cell.sv
rtl/ordered_list_append_delete_top.sv
sim/olad_result_checker.sv
sim/tb_ordered_list_append_delete_top.sv
